// ===== hw/rtl/dip_pkg.sv =====
// ============================================================================
// dip_pkg
// Shared widths, register indexes and parse phases of the decimal integer
// field parser.
// ============================================================================
`default_nettype none

package dip_pkg;

    // Width of the parsed integer type (signed or unsigned per mode).
    localparam int VALUE_BITS = 32;

    // Magnitude holds 0 .. 2^VALUE_BITS; the top value marks saturation.
    localparam int MAG_BITS  = VALUE_BITS + 1;
    // Room for magnitude * 10 + 9.
    localparam int WIDE_BITS = MAG_BITS + 4;
    // Signed compare width: covers the negated magnitude and the 33-bit bounds.
    localparam int CMP_BITS  = (VALUE_BITS + 2 > 34) ? VALUE_BITS + 2 : 34;

    // Bounds and result number are 33-bit two's complement.
    localparam int NUM_BITS  = 33;
    localparam int CFG_BITS  = 33;
    localparam int IDX_BITS  = 2;
    localparam int CHAR_BITS = 8;

    // Configuration register indexes.
    localparam logic [IDX_BITS-1:0] REG_UNSIGNED_MODE = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_MINIMUM_VALUE = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_MAXIMUM_VALUE = 2'd2;

    // Register reset values.
    localparam logic [CFG_BITS-1:0] MINIMUM_RESET = 33'h1_8000_0000;
    localparam logic [CFG_BITS-1:0] MAXIMUM_RESET = 33'h0_7FFF_FFFF;

    // Characters of interest.
    localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_SIGN  = 3'd1,
        PH_DIGIT = 3'd2,
        PH_TRAIL = 3'd3,
        PH_ERROR = 3'd4
    } phase_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dip_char_if.sv =====
// ============================================================================
// dip_char_if
// Character channel: one string byte per transfer.
// ============================================================================
`default_nettype none

interface dip_char_if;
    logic                           valid;
    logic                           ready;
    logic [dip_pkg::CHAR_BITS-1:0]  character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dip_result_if.sv =====
// ============================================================================
// dip_result_if
// Result channel: accept flag and parsed number, one transfer per string.
// ============================================================================
`default_nettype none

interface dip_result_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 accepted;
    logic signed [dip_pkg::NUM_BITS-1:0]  number;

    modport source (output valid, output accepted, output number, input ready);
    modport sink   (input valid, input accepted, input number, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/decimal_integer_field_parser.sv =====
// ============================================================================
// decimal_integer_field_parser
// Streams an ASCII decimal string one byte at a time and reports, on the
// terminating NUL, whether it is a valid in-range integer and its value.
// ============================================================================
//
// Channel   Dir  Payload                  Transfer
// chars     in   character[7:0]           one byte of the string
// results   out  accepted, number[32:0]   one per NUL byte
// cfg       in   cfg_index[1:0], cfg_data write when cfg_write is high
//
// Input takes one byte per cycle whenever the result register is empty
// or being drained. Each byte updates the phase/sign/magnitude registers
// in the cycle it is transferred; a NUL also loads the result register,
// which presents the result the next cycle. Reset returns the parser to
// the leading whitespace phase and restores the default bounds and mode.
// ============================================================================
`default_nettype none

module decimal_integer_field_parser (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    dip_char_if.sink                            chars,
    dip_result_if.source                        results,
    input  wire logic                           cfg_write,
    input  wire logic [dip_pkg::IDX_BITS-1:0]   cfg_index,
    input  wire logic [dip_pkg::CFG_BITS-1:0]   cfg_data
);

    localparam int VB   = dip_pkg::VALUE_BITS;
    localparam int MB   = dip_pkg::MAG_BITS;
    localparam int WB   = dip_pkg::WIDE_BITS;
    localparam int CB   = dip_pkg::CMP_BITS;
    localparam int NB   = dip_pkg::NUM_BITS;

    localparam logic [MB-1:0] MAG_CAP  = {1'b1, {VB{1'b0}}};
    localparam logic [MB-1:0] MAG_HALF = {2'b01, {(VB-1){1'b0}}};
    localparam logic [WB-1:0] WIDE_CAP = {{(WB-MB){1'b0}}, MAG_CAP};

    // Configuration registers
    logic                          unsigned_mode_reg;
    logic [dip_pkg::CFG_BITS-1:0]  minimum_value_reg;
    logic [dip_pkg::CFG_BITS-1:0]  maximum_value_reg;

    // Parse state
    dip_pkg::phase_t  phase_reg, phase_next;
    logic             negative_reg, negative_next;
    logic [MB-1:0]    magnitude_reg, magnitude_next;

    // Result register
    logic             out_valid_reg;
    logic             accepted_reg, accepted_next;
    logic [NB-1:0]    number_reg, number_next;

    logic                          take;
    logic                          is_nul;
    logic                          is_ws;
    logic                          is_digit;
    logic [dip_pkg::CHAR_BITS-1:0] c;
    logic [WB-1:0]                 digit_ext;
    logic [WB-1:0]                 mag_wide;
    logic [WB-1:0]                 acc_wide;
    logic [MB-1:0]                 mag_added;

    logic                 syntax_ok;
    logic                 type_ok;
    logic                 bounds_ordered;
    logic                 in_bounds;
    logic signed [CB-1:0] mag_signed;
    logic signed [CB-1:0] value_signed;
    logic signed [CB-1:0] lo_signed;
    logic signed [CB-1:0] hi_signed;

    assign chars.ready   = !out_valid_reg || results.ready;
    assign take          = chars.valid && chars.ready;
    assign results.valid    = out_valid_reg;
    assign results.accepted = accepted_reg;
    assign results.number   = number_reg;

    assign c        = chars.character;
    assign is_nul   = (c == dip_pkg::CH_NUL);
    assign is_ws    = (c == dip_pkg::CH_SPACE) || ((c >= dip_pkg::CH_TAB) && (c <= dip_pkg::CH_CR));
    assign is_digit = (c >= dip_pkg::CH_ZERO) && (c <= dip_pkg::CH_NINE);

    // Multiply by ten as shift-and-add, then saturate at 2^VALUE_BITS.
    assign digit_ext = {{(WB-4){1'b0}}, 4'(c - dip_pkg::CH_ZERO)};
    assign mag_wide  = {{(WB-MB){1'b0}}, magnitude_reg};
    assign acc_wide  = (mag_wide << 3) + (mag_wide << 1) + digit_ext;
    assign mag_added = (acc_wide > WIDE_CAP) ? MAG_CAP : acc_wide[MB-1:0];

    // ------------------------------------------------------------------
    // Result evaluation from the state left by the bytes before the NUL
    // ------------------------------------------------------------------
    assign syntax_ok  = (phase_reg == dip_pkg::PH_DIGIT) || (phase_reg == dip_pkg::PH_TRAIL);
    assign mag_signed = {{(CB-MB){1'b0}}, magnitude_reg};
    assign value_signed = negative_reg ? -mag_signed : mag_signed;
    assign lo_signed  = {{(CB-NB){minimum_value_reg[NB-1]}}, minimum_value_reg};
    assign hi_signed  = {{(CB-NB){maximum_value_reg[NB-1]}}, maximum_value_reg};
    assign bounds_ordered = !(lo_signed > hi_signed);
    assign in_bounds  = !(value_signed < lo_signed) && !(value_signed > hi_signed);

    always_comb
    begin
        if (unsigned_mode_reg)
        begin
            type_ok = !negative_reg && (magnitude_reg < MAG_CAP);
        end
        else if (negative_reg)
        begin
            type_ok = (magnitude_reg <= MAG_HALF);
        end
        else
        begin
            type_ok = (magnitude_reg < MAG_HALF);
        end
    end

    always_comb
    begin
        accepted_next = syntax_ok && bounds_ordered && type_ok && in_bounds;
        number_next   = accepted_next ? value_signed[NB-1:0] : '0;
    end

    // ------------------------------------------------------------------
    // Phase machine: next state per byte
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next     = phase_reg;
        negative_next  = negative_reg;
        magnitude_next = magnitude_reg;
        if (take)
        begin
            if (is_nul)
            begin
                // Re-arm for the next string.
                phase_next     = dip_pkg::PH_LEAD;
                negative_next  = 1'b0;
                magnitude_next = '0;
            end
            else
            begin
                unique case (phase_reg)
                    dip_pkg::PH_LEAD:
                    begin
                        if (is_ws)
                        begin
                            phase_next = dip_pkg::PH_LEAD;
                        end
                        else if ((c == dip_pkg::CH_PLUS) || (c == dip_pkg::CH_MINUS))
                        begin
                            negative_next = (c == dip_pkg::CH_MINUS);
                            phase_next    = dip_pkg::PH_SIGN;
                        end
                        else if (is_digit)
                        begin
                            magnitude_next = mag_added;
                            phase_next     = dip_pkg::PH_DIGIT;
                        end
                        else
                        begin
                            phase_next = dip_pkg::PH_ERROR;
                        end
                    end
                    dip_pkg::PH_SIGN:
                    begin
                        if (is_digit)
                        begin
                            magnitude_next = mag_added;
                            phase_next     = dip_pkg::PH_DIGIT;
                        end
                        else
                        begin
                            phase_next = dip_pkg::PH_ERROR;
                        end
                    end
                    dip_pkg::PH_DIGIT:
                    begin
                        if (is_digit)
                        begin
                            magnitude_next = mag_added;
                        end
                        else if (is_ws)
                        begin
                            phase_next = dip_pkg::PH_TRAIL;
                        end
                        else
                        begin
                            phase_next = dip_pkg::PH_ERROR;
                        end
                    end
                    dip_pkg::PH_TRAIL:
                    begin
                        if (!is_ws)
                        begin
                            phase_next = dip_pkg::PH_ERROR;
                        end
                    end
                    default:
                    begin
                        phase_next = dip_pkg::PH_ERROR;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= dip_pkg::PH_LEAD;
            negative_reg  <= 1'b0;
            magnitude_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            negative_reg  <= negative_next;
            magnitude_reg <= magnitude_next;
        end
    end

    // Result register: load on a NUL transfer, drop when taken downstream.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take && is_nul)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && is_nul)
        begin
            accepted_reg <= accepted_next;
            number_reg   <= number_next;
        end
    end

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unsigned_mode_reg <= 1'b0;
            minimum_value_reg <= dip_pkg::MINIMUM_RESET;
            maximum_value_reg <= dip_pkg::MAXIMUM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dip_pkg::REG_UNSIGNED_MODE: unsigned_mode_reg <= cfg_data[0];
                dip_pkg::REG_MINIMUM_VALUE: minimum_value_reg <= cfg_data;
                dip_pkg::REG_MAXIMUM_VALUE: maximum_value_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dip_checker.sv =====
// ============================================================================
// dip_checker
// Port-level checks of the decimal integer field parser, bound to the top.
// ============================================================================
`default_nettype none

module dip_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic [dip_pkg::CHAR_BITS-1:0] in_character,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic                          out_accepted,
    input wire logic [dip_pkg::NUM_BITS-1:0]  out_number
);

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_accepted) && $stable(out_number)))
        else $error("stalled result changed");

    // A rejected string reports number zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_accepted) |-> (out_number == '0))
        else $error("rejected result with nonzero number");

    // A NUL transfer produces a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_character == dip_pkg::CH_NUL)) |=> out_valid)
        else $error("NUL without result");

    // Other bytes never create a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_character != dip_pkg::CH_NUL) && !out_valid) |=> !out_valid)
        else $error("result without NUL");

    // With no result pending the parser takes input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

endmodule

bind decimal_integer_field_parser dip_checker u_dip_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (chars.valid),
    .in_ready     (chars.ready),
    .in_character (chars.character),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_accepted (results.accepted),
    .out_number   (results.number)
);

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Decimal integer field parser testbench
// Streams ASCII strings into the parser, one byte per transfer, and checks
// the accept flag and value that each NUL byte produces against an in-bench
// model of the parser or, for typed rows, the table. A short table of
// hand-written strings comes first, then random strings under several bound
// and mode settings, all but one with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dip_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_CHARS   = 145;
    localparam int ROWS          = 25;

    // Index with no register behind it; writes must be ignored.
    localparam logic [IDX_BITS-1:0] REG_SPARE = 2'd3;

    localparam logic [CFG_BITS-1:0] UNSIGNED_TOP = 33'h0_FFFF_FFFF;
    localparam logic [CFG_BITS-1:0] MINUS_FIVE   = 33'h1_FFFF_FFFB;

    typedef struct packed {
        logic                accepted;
        logic [NUM_BITS-1:0] number;
    } verdict_t;

    typedef struct {
        bit                  umode;
        logic [CFG_BITS-1:0] lo;
        logic [CFG_BITS-1:0] hi;
        string               text;
        bit                  typed;
        bit                  ok;
        logic [NUM_BITS-1:0] num;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                cfg_write;
    logic [IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    dip_char_if   chars_if ();
    dip_result_if results_if ();

    decimal_integer_field_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars_if),
        .results   (results_if),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Parser model: configuration copy and per-string state.
    bit                  mode_q = 1'b0;
    logic [CFG_BITS-1:0] lo_q   = MINIMUM_RESET;
    logic [CFG_BITS-1:0] hi_q   = MAXIMUM_RESET;
    phase_t              ph     = PH_LEAD;
    bit                  neg    = 1'b0;
    logic [MAG_BITS-1:0] mag    = '0;

    verdict_t verdicts_due [$];
    bit       gaps_on = 1'b1;
    int       fail_count    = 0;
    int       chars_sent    = 0;
    int       strings_sent  = 0;
    int       accepted_seen = 0;
    int       rejected_seen = 0;

    stim_row_t directed_rows [ROWS] = '{
        '{1'b0, MINIMUM_RESET, MAXIMUM_RESET, "0", 1'b1, 1'b1, 33'h0},
        '{1'b0, MINIMUM_RESET, MAXIMUM_RESET, "2147483647", 1'b1, 1'b1, 33'h0_7FFF_FFFF},
        '{1'b0, MINIMUM_RESET, MAXIMUM_RESET, "-2147483648", 1'b1, 1'b1, 33'h1_8000_0000},
        '{1'b0, MINIMUM_RESET, MAXIMUM_RESET, "2147483648", 1'b1, 1'b0, 33'h0},
        '{1'b0, MINIMUM_RESET, MAXIMUM_RESET, "-2147483649", 1'b1, 1'b0, 33'h0},
        '{1'b0, MINIMUM_RESET, MAXIMUM_RESET, " \011\012\013\014\015+42\040\011",
          1'b0, 1'b0, 33'h0},
        '{1'b0, MINIMUM_RESET, MAXIMUM_RESET, "", 1'b1, 1'b0, 33'h0},
        '{1'b0, MINIMUM_RESET, MAXIMUM_RESET, "+", 1'b1, 1'b0, 33'h0},
        '{1'b0, MINIMUM_RESET, MAXIMUM_RESET, "-", 1'b1, 1'b0, 33'h0},
        '{1'b0, MINIMUM_RESET, MAXIMUM_RESET, "12 3", 1'b1, 1'b0, 33'h0},
        '{1'b0, MINIMUM_RESET, MAXIMUM_RESET, "1x", 1'b1, 1'b0, 33'h0},
        '{1'b0, MINIMUM_RESET, MAXIMUM_RESET, "99999999999999999999", 1'b1, 1'b0, 33'h0},
        '{1'b0, MINIMUM_RESET, MAXIMUM_RESET, "000000000000000000000042",
          1'b0, 1'b0, 33'h0},
        '{1'b0, MINIMUM_RESET, MAXIMUM_RESET, "+-1", 1'b1, 1'b0, 33'h0},
        '{1'b0, MINIMUM_RESET, MAXIMUM_RESET, "  -17\011", 1'b0, 1'b0, 33'h0},
        '{1'b1, 33'h0, UNSIGNED_TOP, "4294967295", 1'b1, 1'b1, 33'h0_FFFF_FFFF},
        '{1'b1, 33'h0, UNSIGNED_TOP, "4294967296", 1'b1, 1'b0, 33'h0},
        '{1'b1, 33'h0, UNSIGNED_TOP, "-0", 1'b1, 1'b0, 33'h0},
        '{1'b1, 33'h0, UNSIGNED_TOP, "+0", 1'b1, 1'b1, 33'h0},
        '{1'b1, MINIMUM_RESET, UNSIGNED_TOP, "3000000000", 1'b0, 1'b0, 33'h0},
        '{1'b0, 33'd10, 33'd5, "7", 1'b1, 1'b0, 33'h0},
        '{1'b0, MINUS_FIVE, 33'd5, "-6", 1'b1, 1'b0, 33'h0},
        '{1'b0, MINUS_FIVE, 33'd5, "-5", 1'b1, 1'b1, MINUS_FIVE},
        '{1'b0, MINUS_FIVE, 33'd5, "5", 1'b1, 1'b1, 33'd5},
        '{1'b0, MINUS_FIVE, 33'd5, "6", 1'b1, 1'b0, 33'h0}
    };

    function automatic longint sext_bound(input logic [CFG_BITS-1:0] b);
        return longint'({{(64-CFG_BITS){b[CFG_BITS-1]}}, b});
    endfunction

    function automatic bit is_space(input logic [CHAR_BITS-1:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Multiply-by-ten accumulate; pin at 2^VALUE_BITS on overflow.
    function automatic void accumulate(input logic [3:0] d);
        logic [WIDE_BITS-1:0] cap;
        cap = '0;
        cap[VALUE_BITS] = 1'b1;
        if (WIDE_BITS'(mag) > (cap - WIDE_BITS'(d)) / 10)
            mag = cap[MAG_BITS-1:0];
        else
            mag = MAG_BITS'(WIDE_BITS'(mag) * 10 + WIDE_BITS'(d));
    endfunction

    function automatic void parse_char(input logic [CHAR_BITS-1:0] c);
        bit is_digit;
        is_digit = c >= CH_ZERO && c <= CH_NINE;
        case (ph)
            PH_LEAD:
            begin
                if (is_space(c))
                    ph = PH_LEAD;
                else if (c == CH_PLUS || c == CH_MINUS)
                begin
                    neg = (c == CH_MINUS);
                    ph  = PH_SIGN;
                end
                else if (is_digit)
                begin
                    accumulate(4'(c - CH_ZERO));
                    ph = PH_DIGIT;
                end
                else
                    ph = PH_ERROR;
            end
            PH_SIGN:
            begin
                if (is_digit)
                begin
                    accumulate(4'(c - CH_ZERO));
                    ph = PH_DIGIT;
                end
                else
                    ph = PH_ERROR;
            end
            PH_DIGIT:
            begin
                if (is_digit)
                    accumulate(4'(c - CH_ZERO));
                else if (is_space(c))
                    ph = PH_TRAIL;
                else
                    ph = PH_ERROR;
            end
            PH_TRAIL:
            begin
                if (!is_space(c))
                    ph = PH_ERROR;
            end
            default:
                ph = PH_ERROR;
        endcase
    endfunction

    // Verdict on the terminating NUL; re-arm for the next string.
    function automatic verdict_t close_string();
        verdict_t r;
        bit       ok;
        longint   lo, hi, val, m, half, umax;
        ok   = (ph == PH_DIGIT || ph == PH_TRAIL);
        lo   = sext_bound(lo_q);
        hi   = sext_bound(hi_q);
        m    = longint'(mag);
        half = longint'(1) << (VALUE_BITS - 1);
        umax = (longint'(1) << VALUE_BITS) - 1;
        val  = 0;
        if (lo > hi)
            ok = 1'b0;
        if (ok)
        begin
            if (mode_q)
            begin
                if (neg || m > umax)
                    ok = 1'b0;
                else
                    val = m;
            end
            else if (neg)
            begin
                if (m > half)
                    ok = 1'b0;
                else
                    val = -m;
            end
            else
            begin
                if (m > half - 1)
                    ok = 1'b0;
                else
                    val = m;
            end
        end
        if (ok && (val < lo || val > hi))
            ok = 1'b0;
        r.accepted = ok;
        r.number   = ok ? val[NUM_BITS-1:0] : '0;
        ph  = PH_LEAD;
        neg = 1'b0;
        mag = '0;
        return r;
    endfunction

    // Hold valid until the transfer; random idle cycles ahead of it if gaps_on is set.
    task automatic send_char(input logic [CHAR_BITS-1:0] c);
        while (gaps_on && $urandom_range(0, 99) < 35)
        begin
            chars_if.valid <= 1'b0;
            @(posedge clk);
        end
        chars_if.valid     <= 1'b1;
        chars_if.character <= c;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_string(input logic [CHAR_BITS-1:0] s [$], input bit typed,
                               input bit ok, input logic [NUM_BITS-1:0] num);
        verdict_t v;
        foreach (s[i])
        begin
            send_char(s[i]);
            parse_char(s[i]);
        end
        send_char(CH_NUL);
        v = close_string();
        if (typed)
        begin
            v.accepted = ok;
            v.number   = num;
        end
        verdicts_due.push_back(v);
        strings_sent++;
    endtask

    task automatic wait_drained();
        chars_if.valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_UNSIGNED_MODE: mode_q = data[0];
            REG_MINIMUM_VALUE: lo_q   = data;
            REG_MAXIMUM_VALUE: hi_q   = data;
            default: ;
        endcase
    endtask

    task automatic apply_config(input bit m, input logic [CFG_BITS-1:0] lo,
                                input logic [CFG_BITS-1:0] hi, input bit poke_spare);
        wait_drained();
        write_reg(REG_UNSIGNED_MODE, {{(CFG_BITS-1){1'b0}}, m});
        write_reg(REG_MINIMUM_VALUE, lo);
        write_reg(REG_MAXIMUM_VALUE, hi);
        if (poke_spare)
            write_reg(REG_SPARE, {1'b1, $urandom()});
        cfg_write <= 1'b0;
    endtask

    function automatic logic [CFG_BITS-1:0] random_bound();
        logic [31:0] r;
        r = $urandom();
        if ($urandom_range(0, 1))
            return {r[31], r};
        return {1'b0, r};
    endfunction

    function automatic logic [CHAR_BITS-1:0] pick_space();
        int k;
        k = $urandom_range(0, 5);
        return (k == 0) ? CH_SPACE : CHAR_BITS'(CH_TAB + k - 1);
    endfunction

    // Values near the current bounds and the type limits.
    function automatic longint pick_edge_value();
        longint v;
        case ($urandom_range(0, 11))
            0:       v = sext_bound(lo_q);
            1:       v = sext_bound(hi_q);
            2:       v = sext_bound(lo_q) - 1;
            3:       v = sext_bound(hi_q) + 1;
            4:       v = 0;
            5:       v = -1;
            6:       v = 64'sd2147483647;
            7:       v = 64'sd2147483648;
            8:       v = -64'sd2147483648;
            9:       v = -64'sd2147483649;
            10:      v = 64'sd4294967295;
            default: v = 64'sd4294967296;
        endcase
        return v;
    endfunction

    task automatic send_random_string();
        logic [CHAR_BITS-1:0] s [$];
        int     kind, len;
        longint v;
        string  digits;
        kind = $urandom_range(0, 99);
        if (kind >= 95)
        begin
            // pure noise
            repeat ($urandom_range(0, 6)) s.push_back(CHAR_BITS'($urandom_range(1, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 2)) s.push_back(pick_space());
            if (kind < 35)
            begin
                v = pick_edge_value();
                if (v < 0)
                begin
                    s.push_back(CH_MINUS);
                    v = -v;
                end
                else if ($urandom_range(0, 3) == 0)
                    s.push_back(CH_PLUS);
                digits = $sformatf("%0d", v);
                for (int i = 0; i < digits.len(); i++)
                    s.push_back(digits[i]);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       s.push_back(CH_PLUS);
                    1:       s.push_back(CH_MINUS);
                    default: ;
                endcase
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 22) : $urandom_range(1, 10);
                repeat (len) s.push_back(CHAR_BITS'(CH_ZERO + $urandom_range(0, 9)));
            end
            repeat ($urandom_range(0, 2)) s.push_back(pick_space());
            if (kind >= 90)
            begin
                // digit after trailing whitespace
                s.push_back(CH_SPACE);
                s.push_back(CHAR_BITS'(CH_ZERO + $urandom_range(0, 9)));
            end
            else if (kind >= 80)
                s[$urandom_range(0, s.size() - 1)] = CHAR_BITS'($urandom_range(1, 255));
        end
        send_string(s, 1'b0, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            results_if.ready <= 1'b0;
        else
            results_if.ready <= !(gaps_on && $urandom_range(0, 99) < 35);
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (verdicts_due.size() == 0)
            begin
                $error("unexpected result transfer: accepted %0b number %h",
                       results_if.accepted, results_if.number);
                fail_count++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (results_if.accepted !== want.accepted)
                begin
                    $error("accepted: expected %0b, actual %0b",
                           want.accepted, results_if.accepted);
                    fail_count++;
                end
                if (results_if.number !== want.number)
                begin
                    $error("number: expected %h, actual %h", want.number, results_if.number);
                    fail_count++;
                end
                if (want.accepted)
                    accepted_seen++;
                else
                    rejected_seen++;
            end
        end
    end

    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        logic [CHAR_BITS-1:0] s [$];
        logic [CFG_BITS-1:0]  lo, hi, tmp;
        bit                   m;
        int                   base;

        rst_n              = 1'b0;
        chars_if.valid     = 1'b0;
        chars_if.character = '0;
        cfg_write          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].umode != mode_q || directed_rows[r].lo != lo_q
                || directed_rows[r].hi != hi_q)
                apply_config(directed_rows[r].umode, directed_rows[r].lo,
                             directed_rows[r].hi, 1'b1);
            s.delete();
            for (int i = 0; i < directed_rows[r].text.len(); i++)
                s.push_back(directed_rows[r].text[i]);
            send_string(s, directed_rows[r].typed, directed_rows[r].ok, directed_rows[r].num);
        end

        for (int p = 0; p < 7; p++)
        begin
            m  = 1'b0;
            lo = random_bound();
            hi = random_bound();
            case (p)
                0:
                begin
                    lo = MINIMUM_RESET;
                    hi = MAXIMUM_RESET;
                end
                1:
                begin
                    m  = 1'b1;
                    lo = '0;
                    hi = UNSIGNED_TOP;
                end
                2:
                begin
                    // negative minimum in unsigned mode
                    m  = 1'b1;
                    lo = MINIMUM_RESET;
                    hi = UNSIGNED_TOP;
                end
                4:
                    m = 1'($urandom_range(0, 1));
                5:
                    m = 1'b1;
                6:
                    hi = lo;
                default: ;
            endcase
            // Keep bounds ordered except in the free-for-all setting.
            if (p != 4 && sext_bound(lo) > sext_bound(hi))
            begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
            apply_config(m, lo, hi, p == 4);
            gaps_on = (p != 2);
            base = chars_sent;
            while (chars_sent - base < PHASE_CHARS)
                send_random_string();
        end

        wait_drained();
        $display("Parsed %0d strings from %0d characters: %0d accepted, %0d rejected",
                 strings_sent, chars_sent, accepted_seen, rejected_seen);
        $display("Covered signed and unsigned modes, ordered, equal and inverted bounds");
        if (fail_count == 0 && verdicts_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
